@@ design/scs_pkg.sv @@
package scs_pkg;

  localparam int ACCEL_ENTRIES = 23;
  localparam int ACCEL_IDX_W   = 5;
  localparam int HALF_PHASES   = 8;
  localparam int FULL_PHASES   = 4;
  localparam int POS_W         = 32;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  typedef logic [3:0] coil_t;
  typedef logic [3:0] delay_t;
  typedef logic [2:0] phase_t;
  typedef logic [ACCEL_IDX_W-1:0] accel_idx_t;
  typedef logic signed [POS_W-1:0] pos_t;

  // request codes on s_tuser
  typedef enum logic [2:0] {
    REQ_STEP        = 3'd0,
    REQ_MOVE        = 3'd1,
    REQ_POWER_OFF   = 3'd2,
    REQ_ACCEL_START = 3'd3,
    REQ_ACCEL_END   = 3'd4
  } req_t;

  // register indexes on the configuration channel
  localparam logic CFG_HALF_STEP_MODE     = 1'b0;
  localparam logic CFG_DIRECTION_INVERTED = 1'b1;

  localparam coil_t HALF_FW [HALF_PHASES] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};
  localparam coil_t HALF_BW [HALF_PHASES] = '{4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};
  localparam coil_t FULL_FW [FULL_PHASES] = '{4'd1, 4'd2, 4'd4, 4'd8};
  localparam coil_t FULL_BW [FULL_PHASES] = '{4'd8, 4'd4, 4'd2, 4'd1};

  localparam delay_t ACCEL_DELAY [ACCEL_ENTRIES] = '{
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd8, 4'd8, 4'd10, 4'd10, 4'd10
  };

  localparam accel_idx_t ACCEL_START_IDX = ACCEL_IDX_W'(ACCEL_ENTRIES - 1);

  typedef struct packed {
    coil_t coils;
    logic  stepped;
    logic  done_res;
    pos_t  position;
  } result_t;

  // entries past the end of the ramp read as zero
  function automatic delay_t accel_delay(input accel_idx_t idx);
    delay_t d;
    d = 4'd0;
    if (int'(idx) < ACCEL_ENTRIES) begin
      d = ACCEL_DELAY[idx];
    end
    return d;
  endfunction

endpackage

@@ design/scs_drive.sv @@
module scs_drive (
  input  logic            half_step_mode,
  input  logic            direction_inverted,
  input  logic            fwd,
  input  scs_pkg::phase_t phase,
  input  scs_pkg::pos_t   position,
  output scs_pkg::coil_t  coils,
  output scs_pkg::phase_t phase_next,
  output scs_pkg::pos_t   position_next
);

  logic            use_fw;
  scs_pkg::phase_t phase_inc;
  logic            wrap;

  assign use_fw = fwd ^ direction_inverted;

  always_comb begin
    if (half_step_mode) begin
      coils = use_fw ? scs_pkg::HALF_FW[phase] : scs_pkg::HALF_BW[phase];
    end else begin
      coils = use_fw ? scs_pkg::FULL_FW[phase[1:0]] : scs_pkg::FULL_BW[phase[1:0]];
    end
  end

  assign phase_inc = phase + 3'd1;
  // end of a full phase cycle
  assign wrap = (phase_inc == 3'd0) || (!half_step_mode && phase_inc[2]);

  assign phase_next = wrap ? 3'd0 : phase_inc;

  always_comb begin
    position_next = position;
    if (wrap) begin
      position_next = fwd ? position + 32'sd1 : position - 32'sd1;
    end
  end

endmodule

@@ design/scs_core.sv @@
module scs_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [2:0]          req_type,
  input  logic                forward,
  input  scs_pkg::pos_t       target_pos,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data,
  output scs_pkg::result_t    result
);

  logic                 half_step_mode;
  logic                 direction_inverted;
  scs_pkg::pos_t        position;
  scs_pkg::phase_t      phase;
  scs_pkg::accel_idx_t  accel_idx;
  scs_pkg::delay_t      delay;
  scs_pkg::coil_t       coils;

  scs_pkg::pos_t        position_next;
  scs_pkg::phase_t      phase_next;
  scs_pkg::accel_idx_t  accel_idx_next;
  scs_pkg::delay_t      delay_next;
  scs_pkg::coil_t       coils_next;
  logic                 stepped;
  logic                 done_res;

  logic                 drv_fwd;
  scs_pkg::coil_t       drv_coils;
  scs_pkg::phase_t      drv_phase;
  scs_pkg::pos_t        drv_position;
  logic                 below;
  logic                 at_target;
  scs_pkg::accel_idx_t  accel_idx_dec;

  assign below         = position < target_pos;
  assign at_target     = position == target_pos;
  assign accel_idx_dec = accel_idx - 5'd1;
  assign drv_fwd       = (req_type == scs_pkg::REQ_MOVE) ? below : forward;

  scs_drive u_drive (
    .half_step_mode     (half_step_mode),
    .direction_inverted (direction_inverted),
    .fwd                (drv_fwd),
    .phase              (phase),
    .position           (position),
    .coils              (drv_coils),
    .phase_next         (drv_phase),
    .position_next      (drv_position)
  );

  always_comb begin
    position_next  = position;
    phase_next     = phase;
    accel_idx_next = accel_idx;
    delay_next     = delay;
    coils_next     = coils;
    stepped        = 1'b0;
    done_res       = 1'b0;
    case (req_type)
      scs_pkg::REQ_STEP: begin
        if (accel_idx != '0 && delay != '0) begin
          // still waiting out the ramp delay
          delay_next = delay - 4'd1;
        end else begin
          if (accel_idx != '0) begin
            accel_idx_next = accel_idx_dec;
            delay_next     = scs_pkg::accel_delay(accel_idx_dec);
          end
          coils_next    = drv_coils;
          phase_next    = drv_phase;
          position_next = drv_position;
          stepped       = 1'b1;
          done_res      = drv_phase == 3'd0;
        end
      end
      scs_pkg::REQ_MOVE: begin
        if (at_target) begin
          coils_next = '0;
          phase_next = '0;
          done_res   = 1'b1;
        end else begin
          coils_next    = drv_coils;
          phase_next    = drv_phase;
          position_next = drv_position;
          stepped       = 1'b1;
        end
      end
      scs_pkg::REQ_POWER_OFF: begin
        coils_next = '0;
        phase_next = '0;
      end
      scs_pkg::REQ_ACCEL_START: begin
        accel_idx_next = scs_pkg::ACCEL_START_IDX;
        delay_next     = scs_pkg::accel_delay(scs_pkg::ACCEL_START_IDX);
      end
      scs_pkg::REQ_ACCEL_END: begin
        accel_idx_next = '0;
        delay_next     = '0;
      end
      default: begin
      end
    endcase
  end

  assign result.coils    = coils_next;
  assign result.stepped  = stepped;
  assign result.done_res = done_res;
  assign result.position = position_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode     <= 1'b1;
      direction_inverted <= 1'b0;
      position           <= '0;
      phase              <= '0;
      accel_idx          <= '0;
      delay              <= '0;
      coils              <= '0;
    end else if (cfg_we) begin
      if (cfg_index == scs_pkg::CFG_HALF_STEP_MODE) begin
        half_step_mode <= cfg_data;
        phase          <= '0;
      end else begin
        direction_inverted <= cfg_data;
      end
    end else if (fire) begin
      position  <= position_next;
      phase     <= phase_next;
      accel_idx <= accel_idx_next;
      delay     <= delay_next;
      coils     <= coils_next;
    end
  end

  // full stepping never leaves the first four phases
  a_full_phase_range: assert property (@(posedge clk) disable iff (rst)
    !half_step_mode |-> !phase[2])
    else $error("phase index beyond full step range");

  a_delay_bound: assert property (@(posedge clk) disable iff (rst)
    delay <= 4'd10)
    else $error("acceleration delay above ramp maximum");

  a_stepped_moves: assert property (@(posedge clk) disable iff (rst)
    fire && !cfg_we && stepped |=> coils != '0)
    else $error("phase driven with all coils off");

  a_no_step_holds_pos: assert property (@(posedge clk) disable iff (rst)
    fire && !cfg_we && !stepped |=> $stable(position))
    else $error("position moved without a step");

endmodule

@@ design/stepper_coil_sequencer.sv @@
// Four-coil stepper sequencer, one request item in and one result item out.
// s_* carries requests: s_tuser holds the request code (step, move, power
// off, accel start, accel end) and s_tdata the direction and move target.
// m_* carries results: coil levels, stepped and done flags, and the position
// counter after the request.
// cfg_* writes register 0 (half step mode, also clears the phase index) or
// register 1 (direction inversion); write only while no request is in flight.
// An accepted item is latched in the input register, worked out against the
// stored stepper state and then written to the result register, which raises
// m_tvalid. One item per cycle is sustained while m_tready stays high; the
// combinational state update between input and result registers sets this.
// When m_tready is low the result register holds and the input register
// fills, then s_tready drops; nothing is lost.
// Reset clears the coils, phase, position and ramp state, selects half step
// mode with normal direction and empties both registers.
module stepper_coil_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [scs_pkg::IN_TDATA_W-1:0]   s_tdata,  // forward, target_pos
  input  logic [2:0]                       s_tuser,  // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [scs_pkg::OUT_TDATA_W-1:0]  m_tdata,  // coils, stepped, done_res, position
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic                             cfg_data
);

  logic             in_valid;
  logic [2:0]       in_req;
  logic             in_fwd;
  scs_pkg::pos_t    in_target;
  logic             advance;
  logic             fire;
  logic             cfg_we;
  scs_pkg::result_t res;
  scs_pkg::result_t out_res;

  assign advance   = !m_tvalid || m_tready;
  assign fire      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req    <= s_tuser;
      in_fwd    <= s_tdata[0];
      in_target <= s_tdata[32:1];
    end
  end

  scs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req_type   (in_req),
    .forward    (in_fwd),
    .target_pos (in_target),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.position, out_res.done_res, out_res.stepped, out_res.coils};

  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("computed item did not reach the result register");

  a_done_move_off: assert property (@(posedge clk) disable iff (rst)
    fire && in_req == scs_pkg::REQ_MOVE && res.done_res |=> out_res.coils == '0)
    else $error("coils left on at move target");

endmodule

@@ dv/scs_checker.sv @@
`timescale 1ns / 100ps

module scs_checker import scs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // forward, target_pos
  input  logic [2:0]             s_tuser,  // req_type
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,  // coils, stepped, done_res, position
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic                   cfg_data,
  output int                     fail_count,
  output int                     compared,
  output int                     outstanding,
  output pos_t                   model_position
);

  // mirrored sequencer state
  logic       half_mode = 1'b1;
  logic       dir_inv   = 1'b0;
  pos_t       pos_cnt   = '0;
  phase_t     phase     = '0;
  accel_idx_t ramp_idx  = '0;
  delay_t     ramp_wait = '0;
  coil_t      coil_now  = '0;

  result_t coil_results_q[$];
  int      fails    = 0;
  int      checks   = 0;
  int      in_queue = 0;
  pos_t    pos_seen = '0;

  assign fail_count     = fails;
  assign compared       = checks;
  assign outstanding    = in_queue;
  assign model_position = pos_seen;

  // drive the next phase; a completed phase cycle moves the position by one
  function automatic void advance_phase(input logic fwd);
    logic   use_fw;
    phase_t nxt;
    int     span;
    use_fw = fwd ^ dir_inv;
    if (half_mode) begin
      coil_now = use_fw ? HALF_FW[phase] : HALF_BW[phase];
      span = HALF_PHASES;
    end else begin
      coil_now = use_fw ? FULL_FW[phase[1:0]] : FULL_BW[phase[1:0]];
      span = FULL_PHASES;
    end
    nxt = phase + 3'd1;
    if (int'(nxt) >= span || nxt == '0) begin
      nxt = '0;
      pos_cnt = fwd ? pos_cnt + 32'sd1 : pos_cnt - 32'sd1;
    end
    phase = nxt;
  endfunction

  function automatic result_t predict_coils(input logic [2:0] code, input logic fwd,
                                            input pos_t tgt);
    result_t r;
    logic    go;
    r = '0;
    go = 1'b1;
    case (code)
      REQ_STEP: begin
        if (ramp_idx != '0) begin
          if (ramp_wait != '0) begin
            ramp_wait = ramp_wait - 4'd1;
            go = 1'b0;
          end else begin
            ramp_idx  = ramp_idx - 5'd1;
            ramp_wait = ACCEL_DELAY[ramp_idx];
          end
        end
        if (go) begin
          advance_phase(fwd);
          r.stepped  = 1'b1;
          r.done_res = (phase == '0);
        end
      end
      REQ_MOVE: begin
        if (pos_cnt < tgt) begin
          advance_phase(1'b1);
          r.stepped = 1'b1;
        end else if (pos_cnt > tgt) begin
          advance_phase(1'b0);
          r.stepped = 1'b1;
        end else begin
          coil_now   = '0;
          phase      = '0;
          r.done_res = 1'b1;
        end
      end
      REQ_POWER_OFF: begin
        coil_now = '0;
        phase    = '0;
      end
      REQ_ACCEL_START: begin
        ramp_idx  = ACCEL_START_IDX;
        ramp_wait = ACCEL_DELAY[ACCEL_START_IDX];
      end
      REQ_ACCEL_END: begin
        ramp_idx  = '0;
        ramp_wait = '0;
      end
      default: ;
    endcase
    r.coils    = coil_now;
    r.position = pos_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    logic    bad;
    if (rst) begin
      half_mode = 1'b1;
      dir_inv   = 1'b0;
      pos_cnt   = '0;
      phase     = '0;
      ramp_idx  = '0;
      ramp_wait = '0;
      coil_now  = '0;
      coil_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HALF_STEP_MODE) begin
          half_mode = cfg_data;
          phase     = '0;
        end else begin
          dir_inv = cfg_data;
        end
      end
      // results always leave after their request is registered, so check before queuing
      if (m_tvalid && m_tready) begin
        got.coils    = m_tdata[3:0];
        got.stepped  = m_tdata[4];
        got.done_res = m_tdata[5];
        got.position = m_tdata[37:6];
        if (coil_results_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got coils %h stepped %b done %b pos %0d",
                   $time, got.coils, got.stepped, got.done_res, got.position);
        end else begin
          want = coil_results_q.pop_front();
          checks++;
          bad = 1'b0;
          if (got.coils !== want.coils) begin
            bad = 1'b1;
            $display("%0t: coils expected %h, got %h", $time, want.coils, got.coils);
          end
          if (got.stepped !== want.stepped) begin
            bad = 1'b1;
            $display("%0t: stepped expected %b, got %b", $time, want.stepped, got.stepped);
          end
          if (got.done_res !== want.done_res) begin
            bad = 1'b1;
            $display("%0t: done_res expected %b, got %b", $time, want.done_res, got.done_res);
          end
          if (got.position !== want.position) begin
            bad = 1'b1;
            $display("%0t: position expected %0d, got %0d", $time, want.position, got.position);
          end
          if (bad) fails++;
        end
      end
      if (s_tvalid && s_tready) begin
        coil_results_q.push_back(predict_coils(s_tuser, s_tdata[0], s_tdata[32:1]));
      end
    end
    in_queue <= coil_results_q.size();
    pos_seen <= pos_cnt;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import scs_pkg::*;

  localparam logic [2:0] REQ_LAST_CODE = 3'd7;
  localparam int         QUIET_LIMIT   = 2000;
  localparam int         PHASE_ITEMS   = 200;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // forward, target_pos
  logic [2:0]             s_tuser   = '0;  // req_type
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // coils, stepped, done_res, position
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic                   cfg_data  = 1'b0;

  int   fail_count;
  int   compared;
  int   outstanding;
  pos_t model_position;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sent           = 0;
  int ignored        = 0;
  int reg_writes     = 0;
  int quiet_cycles   = 0;

  stepper_coil_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scs_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .compared       (compared),
    .outstanding    (outstanding),
    .model_position (model_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // ends the run if no channel moves an item for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("stepper_coil_sequencer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic [2:0] code, input logic fwd, input pos_t tgt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {7'd0, tgt, fwd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (code <= REQ_ACCEL_END) sent++;
    else ignored++;
  endtask

  // hold off requests until every result is back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic run_random(input int quota);
    int   goal;
    int   n;
    int   kind;
    pos_t tgt;
    logic dir;
    goal = sent + quota;
    while (sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        // ramp from accel start, mostly one direction with an odd reversal
        dir = 1'($urandom_range(1));
        send_req(REQ_ACCEL_START, 1'($urandom_range(1)), $urandom());
        n = $urandom_range(150, 5);
        if (n > goal - sent) n = goal - sent;
        repeat (n) send_req(REQ_STEP, dir ^ ($urandom_range(19) == 0), $urandom());
        if ($urandom_range(1)) send_req(REQ_ACCEL_END, 1'($urandom_range(1)), $urandom());
      end else if (kind < 55) begin
        n = $urandom_range(20, 1);
        if (n > goal - sent) n = goal - sent;
        repeat (n) send_req(REQ_STEP, 1'($urandom_range(1)), $urandom());
      end else if (kind < 80) begin
        // target close by so the run settles and powers off at the target
        tgt = model_position + (int'($urandom_range(6)) - 3);
        n = $urandom_range(40, 1);
        if (n > goal - sent) n = goal - sent;
        repeat (n) send_req(REQ_MOVE, 1'($urandom_range(1)), tgt);
      end else if (kind < 88) begin
        tgt = $urandom();
        n = $urandom_range(8, 1);
        if (n > goal - sent) n = goal - sent;
        repeat (n) send_req(REQ_MOVE, 1'($urandom_range(1)), tgt);
      end else begin
        send_req(3'($urandom_range(REQ_LAST_CODE)), 1'($urandom_range(1)), $urandom());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part in the reset settings: half step, normal direction
    send_req(REQ_MOVE, 1'b0, '0);
    repeat (8) send_req(REQ_STEP, 1'b1, '0);
    send_req(REQ_STEP, 1'b0, '0);
    send_req(REQ_MOVE, 1'b1, 32'sh7fff_ffff);
    send_req(REQ_MOVE, 1'b0, 32'sh8000_0000);
    send_req(REQ_POWER_OFF, 1'b1, 32'sh7fff_ffff);
    send_req(REQ_ACCEL_START, 1'b0, '0);
    send_req(REQ_STEP, 1'b1, '0);
    send_req(REQ_STEP, 1'b1, '0);
    send_req(REQ_ACCEL_END, 1'b0, '0);
    send_req(REQ_STEP, 1'b1, '0);
    for (int c = REQ_ACCEL_END + 1; c <= REQ_LAST_CODE; c++) begin
      send_req(3'(c), 1'($urandom_range(1)), $urandom());
    end
    send_req(REQ_MOVE, 1'b1, 32'sd1);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(CFG_HALF_STEP_MODE, p[1] ^ p[2]);
      write_reg(CFG_DIRECTION_INVERTED, p[2]);
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 46;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 46;
        end
        default: begin
          src_idle_pct   = 21;
          sink_stall_pct = 21;
        end
      endcase
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (outstanding != 0) begin
      $display("%0t: %0d results expected, 0 arrived", $time, outstanding);
    end
    $display("%0d requests and %0d unused codes sent, %0d register writes over all mode",
             sent, ignored, reg_writes);
    $display("and direction settings, %0d results compared", compared);
    if (fail_count == 0 && outstanding == 0) begin
      $display("stepper_coil_sequencer test passed");
    end else begin
      $display("stepper_coil_sequencer test failed");
    end
    $finish;
  end

endmodule
